// ===== src/pcm_port_with_rate_timer_assert.svh =====
// Assertion macros used by pcm_core of the PCM port RTL.
// Include by bare file name inside a module that has clk_i and rst_ni.
`ifndef PCM_PORT_WITH_RATE_TIMER_ASSERT_SVH
`define PCM_PORT_WITH_RATE_TIMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pcm_pkg.sv =====
// Shared types and constants of the PCM port with rate timer.
// No dependencies; used by every module in src.
package pcm_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  localparam logic        PORT_TIMER     = 1'b0;
  localparam logic        PORT_STATUS    = 1'b1;
  localparam int unsigned STATUS_ARM_BIT = 0;
  localparam int unsigned STATUS_DAC_BIT = 1;
  localparam logic [1:0]  STROBE_CODE    = 2'b11;

  localparam logic [31:0] TIMER_RATE  = 32'd15750;
  localparam logic [31:0] CLOCK_RESET = 32'd21477270;
  localparam logic [31:0] CLOCK_MIN   = 32'd15751;

  typedef struct packed {
    logic [1:0] kind;
    logic       port;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       dac_strobe;
    logic [7:0] dac_value;
    logic       mixer_enable;
  } result_t;

endpackage

// ===== src/pcm_in_stage.sv =====
// Input register of the PCM port: captures one bus word per cycle while the core takes the held word.
// Depends on pcm_pkg.
module pcm_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] write_data
  input  logic [2:0]    s_axis_tuser,   // [1:0] kind, [2] port
  input  logic          take_i,         // core consumes the held word this cycle
  output logic          valid_o,
  output pcm_pkg::item_t item_o
);
  import pcm_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  fire;

  assign s_axis_tready = !valid_q || take_i;
  assign fire          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (fire) begin
      valid_d         = 1'b1;
      item_d.kind     = s_axis_tuser[1:0];
      item_d.port     = s_axis_tuser[2];
      item_d.write_data = s_axis_tdata;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== src/pcm_core.sv =====
// Device state, timer accumulator and result register of the PCM port.
// Depends on pcm_pkg and pcm_port_with_rate_timer_assert.svh.
`include "pcm_port_with_rate_timer_assert.svh"

module pcm_core #(
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [31:0]     cfg_data_i,
  input  logic            item_valid_i,
  input  pcm_pkg::item_t  item_i,
  output logic            take_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output pcm_pkg::result_t res_o
);
  import pcm_pkg::*;

  localparam int unsigned SumW = ((FRACTION_BITS > 32) ? FRACTION_BITS : 32) + 1;

  logic [31:0]              clk_freq_q;
  logic [7:0]               sample_q, sample_d;
  logic [4:0]               status_q, status_d;
  logic [1:0]               count_q, count_d;
  logic [FRACTION_BITS-1:0] frac_q, frac_d;
  logic                     res_valid_q, res_valid_d;
  result_t                  res_q, res_d;

  logic [31:0]   modulus;
  logic [SumW-1:0] sum, diff;
  logic          wrap;
  logic          out_free;
  logic          load;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !res_valid_q || res_ready_i;
  assign load        = item_valid_i && out_free;
  assign take_o      = out_free;

  // Timer: add the rate, drop by the clock once when the sum reaches it.
  assign modulus = (clk_freq_q < CLOCK_MIN) ? CLOCK_MIN : clk_freq_q;
  assign sum     = SumW'(frac_q) + SumW'(TIMER_RATE);
  assign wrap    = (sum >= SumW'(modulus));
  assign diff    = sum - SumW'(modulus);

  always_comb begin
    sample_d = sample_q;
    status_d = status_q;
    count_d  = count_q;
    frac_d   = frac_q;
    res_d    = '0;
    case (kind_e'(item_i.kind))
      KIND_TICK: begin
        frac_d = wrap ? diff[FRACTION_BITS-1:0] : sum[FRACTION_BITS-1:0];
        if (wrap) begin
          count_d = count_q + 2'd1;
        end
      end
      KIND_READ: begin
        if (item_i.port == PORT_TIMER) begin
          res_d.read_data = {6'd0, count_q};
        end else begin
          res_d.read_data = {~sample_q[7], 2'd0, status_q};
        end
      end
      KIND_WRITE: begin
        if (item_i.port == PORT_TIMER) begin
          count_d  = 2'd0;
          sample_d = item_i.write_data;
          if (status_q[STATUS_DAC_BIT]) begin
            res_d.dac_strobe = 1'b1;
            res_d.dac_value  = item_i.write_data;
          end
        end else begin
          if (item_i.write_data[1:0] == STROBE_CODE && !status_q[STATUS_ARM_BIT]) begin
            res_d.dac_strobe = 1'b1;
            res_d.dac_value  = sample_q;
          end
          status_d = item_i.write_data[4:0];
        end
      end
      default: begin
      end
    endcase
    res_d.mixer_enable = status_d[STATUS_DAC_BIT];
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (load) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_freq_q  <= CLOCK_RESET;
      sample_q    <= '0;
      status_q    <= '0;
      count_q     <= '0;
      frac_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        clk_freq_q <= cfg_data_i;
      end
      if (load) begin
        sample_q <= sample_d;
        status_q <= status_d;
        count_q  <= count_d;
        frac_q   <= frac_d;
      end
    end
  end

  // Hold the result word while stalled.
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `PCM_ASSERT_NOW(a_no_strobe_no_value, res_valid_q && !res_q.dac_strobe,
                  res_q.dac_value == 8'd0, "dac_value set without strobe")
  `PCM_ASSERT_NOW(a_mixer_tracks_status, res_valid_q,
                  res_q.mixer_enable == status_q[STATUS_DAC_BIT],
                  "mixer_enable differs from status")
  `PCM_ASSERT_NEXT(a_sample_write_clears_count,
                   load && item_i.kind == KIND_WRITE && item_i.port == PORT_TIMER,
                   count_q == 2'd0, "sample write left the time counter running")
  `PCM_ASSERT_NEXT(a_read_data_only_on_read, load && item_i.kind != KIND_READ,
                   res_q.read_data == 8'd0, "read_data set on a non-read word")

endmodule

// ===== src/pcm_port_with_rate_timer.sv =====
// Two-port 8-bit PCM device with a 15750 Hz sample timer driven by tick words.
// An input word passes the input register, then the result register, before its
// result word is taken. Throughput: one word per cycle while m_axis_tready is high.
// Reset (rst_ni low, asynchronous): sample, status, counter and fraction clear,
// clock frequency returns to 21477270, both pipeline stages empty.
// Depends on pcm_pkg, pcm_in_stage and pcm_core.
module pcm_port_with_rate_timer #(
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,      // clock_frequency
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] write_data
  input  logic [2:0]  s_axis_tuser,    // [1:0] kind, [2] port
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata     // [7:0] read_data, [8] dac_strobe,
                                       // [16:9] dac_value, [17] mixer_enable
);
  import pcm_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    take;
  result_t res;

  pcm_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take_i        (take),
    .valid_o       (item_valid),
    .item_o        (item)
  );

  pcm_core #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {6'd0, res.mixer_enable, res.dac_value, res.dac_strobe, res.read_data};

endmodule
